### design/sorted_insertion_list_macros.svh
// ----------------------------------------------------------------------------
// Sorted insertion list assertion macros
// Shared property forms for the checks in the sorted insertion list.
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERTION_LIST_MACROS_SVH
`define SORTED_INSERTION_LIST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted insertion list check failed");

// The consequent must hold in the cycle after the antecedent.
`define SIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted insertion list check failed");

`endif

### design/sil_pkg.sv
// ----------------------------------------------------------------------------
// Sorted insertion list package
// Entry type, cell command type and operation codes.
// ----------------------------------------------------------------------------
package sil_pkg;

  localparam int KEY_W  = 16;
  localparam int TAG_W  = 16;
  localparam int FUNC_W = 2;
  localparam int OUT_W  = 6;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } sil_entry_t;

  typedef struct packed {
    logic ins;
    logic rot;
  } sil_cmd_t;

endpackage

### design/sil_cell.sv
// ----------------------------------------------------------------------------
// Sorted insertion list cell
// Holds one entry; on an insert it keeps, takes the new entry or shifts in
// its left neighbor, and on a dump it rotates toward the head.
// ----------------------------------------------------------------------------
module sil_cell
  import sil_pkg::*;
(
  input  logic       clk,
  input  sil_cmd_t   cmd,
  input  sil_entry_t new_entry,
  input  sil_entry_t left_entry,
  input  sil_entry_t right_entry,
  input  sil_entry_t head_entry,
  input  logic       left_stay,
  input  logic       occ,
  input  logic       is_last,
  output sil_entry_t entry,
  output logic       stay
);

  sil_entry_t entry_r;
  sil_entry_t entry_nxt;

  assign stay  = occ && (entry_r.key <= new_entry.key);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (cmd.ins) begin
      if (stay) begin
        entry_nxt = entry_r;
      end else if (left_stay) begin
        entry_nxt = new_entry;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (cmd.rot) begin
      entry_nxt = is_last ? head_entry : right_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### design/sorted_insertion_list.sv
// ----------------------------------------------------------------------------
// Sorted insertion list
// Keeps up to CAPACITY key/tag entries in ascending key order in a row of
// cells, with stable order for equal keys, and reports them on a dump.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports
//  in        input      in_valid, in_ready, in_func, in_key, in_tag
//  out       output     out_valid, out_ready, out_position .. out_last
//
//  Insert, clear, unused codes and an empty dump give one beat.
//  A dump of n > 0 entries gives n beats, one a cycle unless a beat stalls.
//  Inserts find their slot by comparing all cells at once; dumps rotate the
//  row so that the head cell is read out for each beat.
//  A stalled result beat holds the block; reset empties the list at once.
// ----------------------------------------------------------------------------
module sorted_insertion_list
  import sil_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  out_position,
  output logic [KEY_W-1:0]  out_key_out,
  output logic [TAG_W-1:0]  out_tag_out,
  output logic [OUT_W-1:0]  out_count,
  output logic              out_entry_valid,
  output logic              out_dropped,
  output logic              out_last
);

  `include "sorted_insertion_list_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [OUT_W-1:0] pos_r, pos_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic [OUT_W-1:0] cnt_r, cnt_nxt;
  logic             ev_r, ev_nxt;
  logic             drop_r, drop_nxt;
  logic             last_r, last_nxt;

  sil_entry_t           cell_entry [CAPACITY];
  logic [CAPACITY-1:0]  stay;
  logic [CAPACITY-1:0]  boundary;
  logic [IDX_W-1:0]     ins_pos;
  sil_entry_t           new_entry;
  sil_cmd_t             cmd;

  logic out_free;
  logic acc;
  logic full;
  logic dump_emit;
  logic dump_last;

  assign new_entry = '{key: in_key, tag: in_tag};
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign acc       = in_valid && in_ready;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign dump_emit = (state_r == ST_DUMP) && out_free;
  assign dump_last = (CNT_W'(idx_r) == CNT_W'(count_r - 1'b1));

  assign cmd.ins = acc && (in_func == FUNC_INSERT) && !full;
  assign cmd.rot = dump_emit;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sil_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .new_entry   (new_entry),
      .left_entry  ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
      .right_entry ((i == CAPACITY - 1) ? cell_entry[0]
                                        : cell_entry[(i == CAPACITY - 1) ? i : i + 1]),
      .head_entry  (cell_entry[0]),
      .left_stay   ((i == 0) ? 1'b1 : stay[(i == 0) ? 0 : i - 1]),
      .occ         (count_r > CNT_W'(i)),
      .is_last     (count_r == CNT_W'(i + 1)),
      .entry       (cell_entry[i]),
      .stay        (stay[i])
    );
    assign boundary[i] = ((i == 0) ? 1'b1 : stay[(i == 0) ? 0 : i - 1]) && !stay[i];
  end

  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      ins_pos = ins_pos | (IDX_W'(i) & {IDX_W{boundary[i]}});
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    tag_nxt       = tag_r;
    cnt_nxt       = cnt_r;
    ev_nxt        = ev_r;
    drop_nxt      = drop_r;
    last_nxt      = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          out_valid_nxt = 1'b1;
          pos_nxt       = '0;
          key_nxt       = '0;
          tag_nxt       = '0;
          cnt_nxt       = OUT_W'(count_r);
          ev_nxt        = 1'b0;
          drop_nxt      = 1'b0;
          last_nxt      = 1'b1;
          unique case (in_func)
            FUNC_INSERT: begin
              if (full) begin
                drop_nxt = 1'b1;
              end else begin
                count_nxt = count_r + 1'b1;
                pos_nxt   = OUT_W'(ins_pos);
                cnt_nxt   = OUT_W'(count_r + 1'b1);
              end
            end
            FUNC_DUMP: begin
              if (count_r != '0) begin
                out_valid_nxt = 1'b0;
                idx_nxt       = '0;
                state_nxt     = ST_DUMP;
              end
            end
            FUNC_CLEAR: begin
              count_nxt = '0;
              cnt_nxt   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (dump_emit) begin
          out_valid_nxt = 1'b1;
          pos_nxt       = OUT_W'(idx_r);
          key_nxt       = cell_entry[0].key;
          tag_nxt       = cell_entry[0].tag;
          cnt_nxt       = OUT_W'(count_r);
          ev_nxt        = 1'b1;
          drop_nxt      = 1'b0;
          last_nxt      = dump_last;
          idx_nxt       = idx_r + 1'b1;
          if (dump_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    key_r  <= key_nxt;
    tag_r  <= tag_nxt;
    cnt_r  <= cnt_nxt;
    ev_r   <= ev_nxt;
    drop_r <= drop_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_position    = pos_r;
  assign out_key_out     = key_r;
  assign out_tag_out     = tag_r;
  assign out_count       = cnt_r;
  assign out_entry_valid = ev_r;
  assign out_dropped     = drop_r;
  assign out_last        = last_r;

  `SIL_ASSERT_IMPLY(a_count_range, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY))
  `SIL_ASSERT_IMPLY(a_no_accept_in_dump, clk, rst_n, state_r == ST_DUMP, !in_ready)
  `SIL_ASSERT_NEXT(a_insert_grows, clk, rst_n, cmd.ins, count_r == $past(count_r) + 1'b1)
  `SIL_ASSERT_NEXT(a_dump_ends, clk, rst_n, dump_emit && dump_last,
                   state_r == ST_IDLE && out_valid_r && last_r)

endmodule
